// File: sv/i2ctpd_pkg.sv
// i2ctpd_pkg: shared types and constants for the i2c transfer packet decoder
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package i2ctpd_pkg;

   localparam int DATA_DEPTH = 32;
   localparam int INDEX_W    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(DATA_DEPTH + 1);

   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 10;
   localparam int FLAGS_W  = 8;
   localparam int INDEX8_W = 8;
   localparam int LENGTH_W = 6;

   localparam int FL_NACK       = 0;
   localparam int FL_ADDRERR    = 1;
   localparam int FL_TRUNC      = 2;
   localparam int FL_INCOMPLETE = 3;
   localparam int FL_RESTART    = 4;

   localparam logic [4:0]          TEN_BIT_PREFIX = 5'b11110;
   localparam logic [INDEX8_W-1:0] NACK_NONE      = 8'd255;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_STOP = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LOWADDR = 2'd1,
      PH_DATA    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN     = 2'd0,
      ST_SUMMARY = 2'd1,
      ST_DATA    = 2'd2
   } state_type;

   typedef struct packed {
      logic               write_en;
      logic [INDEX_W-1:0] write_index;
      logic               shift_en;
   } chain_ctrl_type;

endpackage

`default_nettype wire

// File: sv/i2c_transfer_packet_decoder_unit.sv
// i2c_transfer_packet_decoder_unit: top level, header parser, packet state and replay control
// depends on i2ctpd_pkg and i2ctpd_chain
//
// usage:
//   req channel carries one bus event per beat: a byte with its ack bit (op 0) or a
//   stop / repeated start condition with flags (op 1). rsp channel carries result beats.
//   a byte beat is absorbed and gives no result; req_ready stays high.
//   a stop beat while a transfer is active starts a run: the summary beat is offered on
//   the next cycle, then every stored data byte in arrival order, one beat per cycle
//   while rsp_ready is high. rsp_last marks the final beat of the run.
//   a stop when no transfer is active gives no result.
//   during a run req_ready is low; a run of N stored bytes gives a summary beat and N
//   data beats. the byte chain shifts one cell toward its head per delivered data beat.
//   when rsp_ready is low the current beat holds unchanged until taken.
//   reset (synchronous, active high) clears the transfer, the selected address and the
//   replay control; the byte cells are not cleared and only cells written in the
//   current transfer are ever read.
`timescale 1ns / 1ps
`default_nettype none

module i2c_transfer_packet_decoder_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_op,
   input  wire logic [7:0]                           req_byte_value,
   input  wire logic                                 req_acknowledged,
   input  wire logic [7:0]                           req_stop_flags,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_is_data,
   output logic      [9:0]                           rsp_address,
   output logic                                      rsp_read,
   output logic                                      rsp_ten_bit,
   output logic      [7:0]                           rsp_flags,
   output logic      [7:0]                           rsp_nack_index,
   output logic      [5:0]                           rsp_length,
   output logic      [7:0]                           rsp_data_byte,
   output logic                                      rsp_last
);

   localparam int CW = i2ctpd_pkg::COUNT_W;

   i2ctpd_pkg::state_type st_ff, st_in;
   i2ctpd_pkg::phase_type phase_ff, phase_in;

   logic                                  active_ff, active_in;
   logic [i2ctpd_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic                                  read_ff, read_in;
   logic                                  ten_ff, ten_in;
   logic [i2ctpd_pkg::FLAGS_W-1:0]        flags_ff, flags_in;
   logic [i2ctpd_pkg::INDEX8_W-1:0]       nack_ff, nack_in;
   logic [CW-1:0]                         count_ff, count_in;
   logic [CW-1:0]                         pos_ff, pos_in;
   logic [i2ctpd_pkg::ADDR_W-1:0]         sel_addr_ff, sel_addr_in;
   logic                                  sel_valid_ff, sel_valid_in;

   logic                                  req_fire;
   logic                                  rsp_fire;
   logic                                  stop_run;
   logic                                  run_done;
   logic                                  pos_is_last;
   logic [i2ctpd_pkg::BYTE_W-1:0]         head;
   i2ctpd_pkg::chain_ctrl_type            chain_ctrl;

   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid && rsp_ready;
   assign stop_run    = req_fire && (req_op == i2ctpd_pkg::OP_STOP) && active_ff;
   assign pos_is_last = ((pos_ff + CW'(1)) == count_ff);
   assign run_done    = rsp_fire &&
                        (((st_ff == i2ctpd_pkg::ST_SUMMARY) && (count_ff == '0)) ||
                         ((st_ff == i2ctpd_pkg::ST_DATA) && pos_is_last));

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         i2ctpd_pkg::ST_RUN: begin
            if (stop_run) begin
               st_in = i2ctpd_pkg::ST_SUMMARY;
            end
         end
         i2ctpd_pkg::ST_SUMMARY: begin
            if (rsp_fire) begin
               st_in = (count_ff == '0) ? i2ctpd_pkg::ST_RUN : i2ctpd_pkg::ST_DATA;
            end
         end
         i2ctpd_pkg::ST_DATA: begin
            if (rsp_fire && pos_is_last) begin
               st_in = i2ctpd_pkg::ST_RUN;
            end
         end
         default: begin
            st_in = i2ctpd_pkg::ST_RUN;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      rsp_is_data = 1'b0;
      case (st_ff)
         i2ctpd_pkg::ST_RUN: begin
            req_ready = 1'b1;
         end
         i2ctpd_pkg::ST_SUMMARY: begin
            rsp_valid = 1'b1;
         end
         i2ctpd_pkg::ST_DATA: begin
            rsp_valid   = 1'b1;
            rsp_is_data = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_address    = addr_ff;
   assign rsp_read       = read_ff;
   assign rsp_ten_bit    = ten_ff;
   assign rsp_flags      = flags_ff;
   assign rsp_nack_index = nack_ff;
   assign rsp_length     = i2ctpd_pkg::LENGTH_W'(count_ff);
   assign rsp_data_byte  = rsp_is_data ? head : '0;
   assign rsp_last       = (st_ff == i2ctpd_pkg::ST_SUMMARY) ? (count_ff == '0) : pos_is_last;

   // packet datapath
   always_comb begin
      logic [i2ctpd_pkg::INDEX8_W-1:0] idx;
      logic                            is_ten;

      phase_in     = phase_ff;
      active_in    = active_ff;
      addr_in      = addr_ff;
      read_in      = read_ff;
      ten_in       = ten_ff;
      flags_in     = flags_ff;
      nack_in      = nack_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      sel_addr_in  = sel_addr_ff;
      sel_valid_in = sel_valid_ff;
      chain_ctrl   = '0;
      idx          = '0;
      is_ten       = (req_byte_value[7:3] == i2ctpd_pkg::TEN_BIT_PREFIX);

      if (req_fire && (req_op == i2ctpd_pkg::OP_BYTE)) begin
         case (phase_ff)
            i2ctpd_pkg::PH_HEADER: begin
               active_in = 1'b1;
               read_in   = req_byte_value[0];
               ten_in    = is_ten;
               if (is_ten) begin
                  addr_in = {req_byte_value[2:1], 8'b0};
                  if (req_byte_value[0]) begin
                     if (sel_valid_ff && (sel_addr_ff[9:8] == req_byte_value[2:1])) begin
                        addr_in = sel_addr_ff;
                     end else begin
                        flags_in[i2ctpd_pkg::FL_ADDRERR] = 1'b1;
                     end
                     phase_in = i2ctpd_pkg::PH_DATA;
                  end else begin
                     sel_valid_in = 1'b0;
                     phase_in     = i2ctpd_pkg::PH_LOWADDR;
                  end
               end else begin
                  addr_in      = {3'b0, req_byte_value[7:1]};
                  sel_valid_in = 1'b0;
                  phase_in     = i2ctpd_pkg::PH_DATA;
               end
            end
            i2ctpd_pkg::PH_LOWADDR: begin
               addr_in      = addr_ff | {2'b0, req_byte_value};
               phase_in     = i2ctpd_pkg::PH_DATA;
               sel_valid_in = req_acknowledged && !flags_ff[i2ctpd_pkg::FL_NACK];
               sel_addr_in  = addr_ff | {2'b0, req_byte_value};
            end
            default: begin
               if (count_ff < CW'(i2ctpd_pkg::DATA_DEPTH)) begin
                  chain_ctrl.write_en    = 1'b1;
                  chain_ctrl.write_index = count_ff[i2ctpd_pkg::INDEX_W-1:0];
                  count_in               = count_ff + CW'(1);
                  idx                    = i2ctpd_pkg::INDEX8_W'(count_ff + CW'(1));
               end else begin
                  flags_in[i2ctpd_pkg::FL_TRUNC] = 1'b1;
                  idx                            = i2ctpd_pkg::NACK_NONE;
               end
            end
         endcase
         if (!req_acknowledged) begin
            if (!flags_ff[i2ctpd_pkg::FL_NACK]) begin
               nack_in = idx;
            end
            flags_in[i2ctpd_pkg::FL_NACK] = 1'b1;
         end
      end

      if (req_fire && (req_op == i2ctpd_pkg::OP_STOP)) begin
         if (active_ff) begin
            flags_in = flags_ff | req_stop_flags;
            if (phase_ff == i2ctpd_pkg::PH_LOWADDR) begin
               flags_in[i2ctpd_pkg::FL_INCOMPLETE] = 1'b1;
            end
            pos_in = '0;
         end
         if (!req_stop_flags[i2ctpd_pkg::FL_RESTART]) begin
            sel_valid_in = 1'b0;
         end
      end

      if (rsp_fire && (st_ff == i2ctpd_pkg::ST_DATA)) begin
         chain_ctrl.shift_en = 1'b1;
         pos_in              = pos_ff + CW'(1);
      end

      if (run_done) begin
         phase_in  = i2ctpd_pkg::PH_HEADER;
         active_in = 1'b0;
         addr_in   = '0;
         read_in   = 1'b0;
         ten_in    = 1'b0;
         flags_in  = '0;
         nack_in   = i2ctpd_pkg::NACK_NONE;
         count_in  = '0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= i2ctpd_pkg::ST_RUN;
         phase_ff     <= i2ctpd_pkg::PH_HEADER;
         active_ff    <= 1'b0;
         addr_ff      <= '0;
         read_ff      <= 1'b0;
         ten_ff       <= 1'b0;
         flags_ff     <= '0;
         nack_ff      <= i2ctpd_pkg::NACK_NONE;
         count_ff     <= '0;
         pos_ff       <= '0;
         sel_addr_ff  <= '0;
         sel_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         addr_ff      <= addr_in;
         read_ff      <= read_in;
         ten_ff       <= ten_in;
         flags_ff     <= flags_in;
         nack_ff      <= nack_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         sel_addr_ff  <= sel_addr_in;
         sel_valid_ff <= sel_valid_in;
      end
   end

   i2ctpd_chain u_chain (
      .clock      (clock),
      .ctrl       (chain_ctrl),
      .write_data (req_byte_value),
      .head       (head)
   );

   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted during a run");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(i2ctpd_pkg::DATA_DEPTH))
      else $error("stored count beyond depth");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == i2ctpd_pkg::ST_DATA) |-> (pos_ff < count_ff))
      else $error("replay position beyond stored count");

   a_stop_starts_run: assert property (@(posedge clock) disable iff (reset)
      stop_run |=> (rsp_valid && !rsp_is_data))
      else $error("stop on active transfer gave no summary beat");

   a_run_end_clears: assert property (@(posedge clock) disable iff (reset)
      run_done |=> (!active_ff && (count_ff == '0) && req_ready))
      else $error("transfer not cleared after run");

endmodule

`default_nettype wire

// File: sv/i2ctpd_cell.sv
// i2ctpd_cell: one byte cell of the data chain, loads directly or takes its neighbor
// depends on i2ctpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2ctpd_cell (
   input  wire logic                            clock,
   input  wire logic                            load_en,
   input  wire logic [i2ctpd_pkg::BYTE_W-1:0]   load_data,
   input  wire logic                            shift_en,
   input  wire logic [i2ctpd_pkg::BYTE_W-1:0]   shift_in,
   output logic      [i2ctpd_pkg::BYTE_W-1:0]   value
);

   logic [i2ctpd_pkg::BYTE_W-1:0] value_ff;
   logic [i2ctpd_pkg::BYTE_W-1:0] value_in;

   always_comb begin
      if (load_en) begin
         value_in = load_data;
      end else if (shift_en) begin
         value_in = shift_in;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// File: sv/i2ctpd_chain.sv
// i2ctpd_chain: row of byte cells; writes at an index, replays by shifting toward cell 0
// depends on i2ctpd_pkg and i2ctpd_cell
`timescale 1ns / 1ps
`default_nettype none

module i2ctpd_chain (
   input  wire logic                               clock,
   input  wire i2ctpd_pkg::chain_ctrl_type         ctrl,
   input  wire logic [i2ctpd_pkg::BYTE_W-1:0]      write_data,
   output logic      [i2ctpd_pkg::BYTE_W-1:0]      head
);

   logic [i2ctpd_pkg::BYTE_W-1:0] cell_value [i2ctpd_pkg::DATA_DEPTH];

   for (genvar i = 0; i < i2ctpd_pkg::DATA_DEPTH; i++) begin : g_cell
      logic                          load_en;
      logic [i2ctpd_pkg::BYTE_W-1:0] shift_in;

      assign load_en = ctrl.write_en &&
                       (ctrl.write_index == i2ctpd_pkg::INDEX_W'(i));

      if (i == i2ctpd_pkg::DATA_DEPTH - 1) begin : g_tail
         assign shift_in = '0;
      end else begin : g_body
         assign shift_in = cell_value[i+1];
      end

      i2ctpd_cell u_cell (
         .clock     (clock),
         .load_en   (load_en),
         .load_data (write_data),
         .shift_en  (ctrl.shift_en),
         .shift_in  (shift_in),
         .value     (cell_value[i])
      );
   end

   assign head = cell_value[0];

endmodule

`default_nettype wire

// File: dv/tb_i2c_transfer_packet_decoder_unit.sv
// tb_i2c_transfer_packet_decoder_unit: self-checking bench for the i2c transfer packet decoder
// drives bus byte and stop beats, predicts summary and data beats, compares them field by field
// depends on i2ctpd_pkg and i2c_transfer_packet_decoder_unit
`timescale 1ns / 1ps

module tb_i2c_transfer_packet_decoder_unit;

   typedef struct {
      logic       op;
      logic [7:0] byte_value;
      logic       ack;
      logic [7:0] stop_flags;
      logic       wait_drain;
   } bus_event_type;

   typedef struct {
      logic       is_data;
      logic [9:0] address;
      logic       read;
      logic       ten_bit;
      logic [7:0] flags;
      logic [7:0] nack_index;
      logic [5:0] length;
      logic [7:0] data_byte;
      logic       last;
   } packet_beat_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_ITEMS     = 25;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_op           = 1'b0;
   logic [7:0] req_byte_value   = 8'd0;
   logic       req_acknowledged = 1'b0;
   logic [7:0] req_stop_flags   = 8'd0;
   logic       rsp_ready        = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_is_data;
   logic [9:0] rsp_address;
   logic       rsp_read;
   logic       rsp_ten_bit;
   logic [7:0] rsp_flags;
   logic [7:0] rsp_nack_index;
   logic [5:0] rsp_length;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;

   i2c_transfer_packet_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_byte_value   (req_byte_value),
      .req_acknowledged (req_acknowledged),
      .req_stop_flags   (req_stop_flags),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_data      (rsp_is_data),
      .rsp_address      (rsp_address),
      .rsp_read         (rsp_read),
      .rsp_ten_bit      (rsp_ten_bit),
      .rsp_flags        (rsp_flags),
      .rsp_nack_index   (rsp_nack_index),
      .rsp_length       (rsp_length),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last         (rsp_last)
   );

   always #2 clock = ~clock;

   bus_event_type   bus_events[$];
   packet_beat_type packet_beats[$];
   bus_event_type   cur_event;
   int           events_sent   = 0;
   int           total_events  = 0;
   int           send_gap      = 0;
   int           recv_idle     = 0;
   int           recv_hold     = 0;
   bit           long_hold_done = 1'b0;
   int           beats_seen    = 0;
   int           fail_count    = 0;
   int           quiet_cycles  = 0;

   // decoder state as the testbench sees it
   i2ctpd_pkg::phase_type tr_phase;
   bit         tr_active;
   logic [9:0] tr_address;
   logic       tr_read;
   logic       tr_ten_bit;
   logic [7:0] tr_flags;
   logic [7:0] tr_nack_index;
   int         tr_count;
   logic [7:0] tr_store [i2ctpd_pkg::DATA_DEPTH];
   logic [9:0] sel_address;
   bit         sel_valid;

   function automatic packet_beat_type make_beat(logic is_data, logic [7:0] data, logic last);
      packet_beat_type p;
      p.is_data    = is_data;
      p.address    = tr_address;
      p.read       = tr_read;
      p.ten_bit    = tr_ten_bit;
      p.flags      = tr_flags;
      p.nack_index = tr_nack_index;
      p.length     = tr_count[5:0];
      p.data_byte  = data;
      p.last       = last;
      return p;
   endfunction

   task automatic clear_transfer();
      tr_phase      = i2ctpd_pkg::PH_HEADER;
      tr_active     = 1'b0;
      tr_address    = '0;
      tr_read       = 1'b0;
      tr_ten_bit    = 1'b0;
      tr_flags      = '0;
      tr_nack_index = i2ctpd_pkg::NACK_NONE;
      tr_count      = 0;
   endtask

   task automatic decode_bus_event(input bus_event_type ev);
      logic [7:0] b;
      logic [7:0] sf;
      logic [7:0] idx;
      b   = ev.byte_value;
      sf  = ev.stop_flags;
      idx = 8'd0;
      if (ev.op == i2ctpd_pkg::OP_BYTE) begin
         case (tr_phase)
            i2ctpd_pkg::PH_HEADER: begin
               tr_active  = 1'b1;
               tr_read    = b[0];
               tr_ten_bit = (b[7:3] == i2ctpd_pkg::TEN_BIT_PREFIX);
               if (tr_ten_bit) begin
                  tr_address = {b[2:1], 8'd0};
                  if (tr_read) begin
                     if (sel_valid && sel_address[9:8] == b[2:1])
                        tr_address = sel_address;
                     else
                        tr_flags[i2ctpd_pkg::FL_ADDRERR] = 1'b1;
                     tr_phase = i2ctpd_pkg::PH_DATA;
                  end else begin
                     sel_valid = 1'b0;
                     tr_phase  = i2ctpd_pkg::PH_LOWADDR;
                  end
               end else begin
                  tr_address = {3'd0, b[7:1]};
                  sel_valid  = 1'b0;
                  tr_phase   = i2ctpd_pkg::PH_DATA;
               end
            end
            i2ctpd_pkg::PH_LOWADDR: begin
               tr_address  = tr_address | {2'd0, b};
               tr_phase    = i2ctpd_pkg::PH_DATA;
               sel_valid   = ev.ack && !tr_flags[i2ctpd_pkg::FL_NACK];
               sel_address = tr_address;
            end
            default: begin
               if (tr_count < i2ctpd_pkg::DATA_DEPTH) begin
                  tr_store[tr_count] = b;
                  tr_count++;
                  idx = tr_count[7:0];
               end else begin
                  tr_flags[i2ctpd_pkg::FL_TRUNC] = 1'b1;
                  idx = i2ctpd_pkg::NACK_NONE;
               end
            end
         endcase
         if (!ev.ack) begin
            if (!tr_flags[i2ctpd_pkg::FL_NACK])
               tr_nack_index = idx;
            tr_flags[i2ctpd_pkg::FL_NACK] = 1'b1;
         end
      end else begin
         if (tr_active) begin
            if (tr_phase == i2ctpd_pkg::PH_LOWADDR)
               sf[i2ctpd_pkg::FL_INCOMPLETE] = 1'b1;
            tr_flags = tr_flags | sf;
            packet_beats.push_back(make_beat(1'b0, 8'd0, tr_count == 0));
            for (int i = 0; i < tr_count; i++)
               packet_beats.push_back(make_beat(1'b1, tr_store[i], i + 1 == tr_count));
            clear_transfer();
         end
         if (!sf[i2ctpd_pkg::FL_RESTART])
            sel_valid = 1'b0;
      end
   endtask

   task automatic push_event(input logic op, input logic [7:0] b, input logic ack,
                             input logic [7:0] sf);
      bus_event_type ev;
      ev.op         = op;
      ev.byte_value = b;
      ev.ack        = ack;
      ev.stop_flags = sf;
      ev.wait_drain = 1'b0;
      bus_events.push_back(ev);
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_bus_event(cur_event);
            events_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (bus_events.size() > 0 &&
                         (!bus_events[0].wait_drain || packet_beats.size() == 0)) begin
               cur_event = bus_events.pop_front();
               req_op           <= cur_event.op;
               req_byte_value   <= cur_event.byte_value;
               req_acknowledged <= cur_event.ack;
               req_stop_flags   <= cur_event.stop_flags;
               req_valid        <= 1'b1;
               if (bus_events.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (packet_beats.size() == 0) begin
               $error("unexpected result beat, data_byte %0d", rsp_data_byte);
               fail_count++;
            end else begin
               packet_beat_type e;
               e = packet_beats.pop_front();
               check_field("is_data", 32'(e.is_data), 32'(rsp_is_data));
               check_field("address", 32'(e.address), 32'(rsp_address));
               check_field("read", 32'(e.read), 32'(rsp_read));
               check_field("ten_bit", 32'(e.ten_bit), 32'(rsp_ten_bit));
               check_field("flags", 32'(e.flags), 32'(rsp_flags));
               check_field("nack_index", 32'(e.nack_index), 32'(rsp_nack_index));
               check_field("length", 32'(e.length), 32'(rsp_length));
               check_field("data_byte", 32'(e.data_byte), 32'(rsp_data_byte));
               check_field("last", 32'(e.last), 32'(rsp_last));
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && beats_seen >= 30) begin
            // long back-pressure mid run so the stop beats pile up at the input
            long_hold_done = 1'b1;
            recv_hold      = LONG_HOLD;
            rsp_ready     <= 1'b0;
         end else if (recv_idle > 0) begin
            recv_idle--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (bus_events.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0)
               recv_idle = $urandom_range(1, 15);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("i2c_transfer_packet_decoder_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] hdr;
      logic [7:0] sf;
      logic [1:0] hi;
      logic [1:0] last_hi;
      int         pick;
      int         kind;
      int         n_data;
      bit         follow_read;
      bit         long_done;

      last_hi     = 2'd0;
      follow_read = 1'b0;
      long_done   = 1'b0;
      clear_transfer();
      sel_address = '0;
      sel_valid   = 1'b0;

      // stop with nothing active
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h00);
      // 7-bit read at the top address, two nacked data bytes, passed-through flag bits
      push_event(i2ctpd_pkg::OP_BYTE, 8'hFF, 1'b1, 8'hFF);
      push_event(i2ctpd_pkg::OP_BYTE, 8'h00, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_BYTE, 8'hFF, 1'b0, 8'h00);
      push_event(i2ctpd_pkg::OP_BYTE, 8'h55, 1'b0, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'hFF, 1'b0, 8'hE0);
      // nack in the address phase, empty packet
      push_event(i2ctpd_pkg::OP_BYTE, 8'h00, 1'b0, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h00);
      // 10-bit write selects 0x3ff, repeated start keeps it
      push_event(i2ctpd_pkg::OP_BYTE, 8'hF6, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_BYTE, 8'hFF, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_BYTE, 8'hA5, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h10);
      // 10-bit read that matches the selection
      push_event(i2ctpd_pkg::OP_BYTE, 8'hF7, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_BYTE, 8'h3C, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h10);
      // 10-bit read with other prefix bits: address error
      push_event(i2ctpd_pkg::OP_BYTE, 8'hF3, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h00);
      // stop right after a 10-bit write header: incomplete
      push_event(i2ctpd_pkg::OP_BYTE, 8'hF0, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h0F);
      // nacked low address leaves no selection for the read
      push_event(i2ctpd_pkg::OP_BYTE, 8'hF2, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_BYTE, 8'h00, 1'b0, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h10);
      push_event(i2ctpd_pkg::OP_BYTE, 8'hF3, 1'b1, 8'h00);
      push_event(i2ctpd_pkg::OP_STOP, 8'h00, 1'b1, 8'h00);

      while (bus_events.size() < 120) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            push_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else if (pick == 1) begin
            push_event(i2ctpd_pkg::OP_STOP, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            kind = follow_read ? 3 : $urandom_range(0, 3);
            hi   = 2'($urandom_range(0, 3));
            case (kind)
               2:       hdr = {i2ctpd_pkg::TEN_BIT_PREFIX, hi, 1'b0};
               3:       hdr = {i2ctpd_pkg::TEN_BIT_PREFIX, follow_read ? last_hi : hi, 1'b1};
               default: hdr = 8'($urandom_range(0, 255));
            endcase
            push_event(i2ctpd_pkg::OP_BYTE, hdr, $urandom_range(0, 9) != 0,
                       8'($urandom_range(0, 255)));
            if (!long_done)
               n_data = 34;
            else if ($urandom_range(0, 19) == 0)
               n_data = $urandom_range(30, 36);
            else
               n_data = $urandom_range(0, 6);
            long_done = 1'b1;
            if (kind == 2) begin
               last_hi = hi;
               if ($urandom_range(0, 7) == 0)
                  n_data = 0;
               else
                  push_event(i2ctpd_pkg::OP_BYTE, 8'($urandom_range(0, 255)),
                             $urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)));
            end
            for (int i = 0; i < n_data; i++)
               push_event(i2ctpd_pkg::OP_BYTE, 8'($urandom_range(0, 255)),
                          $urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)));
            sf          = 8'($urandom_range(0, 255));
            follow_read = 1'b0;
            if (kind == 2 && $urandom_range(0, 1) == 1) begin
               sf[i2ctpd_pkg::FL_RESTART] = 1'b1;
               follow_read                = 1'b1;
            end
            push_event(i2ctpd_pkg::OP_STOP, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), sf);
         end
      end
      // the sender waits for every pending result before these
      bus_events[24].wait_drain = 1'b1;
      bus_events[100].wait_drain = 1'b1;
      total_events = bus_events.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (events_sent < total_events || packet_beats.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (fail_count == 0)
         $display("i2c_transfer_packet_decoder_unit: match");
      else
         $display("i2c_transfer_packet_decoder_unit: mismatch");
      $finish;
   end

endmodule

// File: i2c_transfer_packet_decoder_unit.f
sv/i2ctpd_pkg.sv
sv/i2ctpd_cell.sv
sv/i2ctpd_chain.sv
sv/i2c_transfer_packet_decoder_unit.sv
dv/tb_i2c_transfer_packet_decoder_unit.sv
